>>> hdl/triangle_barycentric_weights_unit_defines.svh
// Assertion macros for the barycentric weights unit.
// No dependencies; expects clk and rst_n in the using scope.
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_UNIT_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_UNIT_DEFINES_SVH

// Implication checked in the same cycle, idle during reset
`define TBW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbw check failed");

// Implication checked in the cycle after the antecedent, idle during reset
`define TBW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbw check failed");

`endif

>>> hdl/tbw_pkg.sv
// Shared constants, types and helpers for the barycentric weights unit.
// No dependencies.
package tbw_pkg;

  localparam int FRAC_BITS = 24;
  // Magnitude of numerator and determinant: up to 2^31
  localparam int MAG_W = 32;
  // Scaled dividend width: magnitude shifted plus rounding carry
  localparam int DIV_W = MAG_W + FRAC_BITS + 1;
  // Signed quotient width
  localparam int QS_W = DIV_W + 1;
  // Width of weight of a before saturation
  localparam int WA_W = QS_W + 2;

  typedef struct packed {
    logic neg_b;
    logic neg_c;
    logic degen;
  } side_t;

  // Clamp a wide signed value into 32 bits
  function automatic logic [31:0] sat32(input logic signed [WA_W-1:0] v);
    logic signed [WA_W-1:0] hi;
    logic signed [WA_W-1:0] lo;
    hi = WA_W'(32'sh7fffffff);
    lo = -(WA_W'(33'sh0_8000_0000));
    if (v > hi) begin
      sat32 = 32'h7fffffff;
    end else if (v < lo) begin
      sat32 = 32'h80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

>>> hdl/tbw_front.sv
// Front pipeline: edge vectors, cross products, magnitudes and scaled dividends.
// Depends on tbw_pkg.
module tbw_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_v,
  input  logic signed [15:0]                ax,
  input  logic signed [15:0]                ay,
  input  logic signed [15:0]                bx,
  input  logic signed [15:0]                by,
  input  logic signed [15:0]                cx,
  input  logic signed [15:0]                cy,
  input  logic signed [15:0]                px,
  input  logic signed [15:0]                py,
  output logic                              out_v,
  output logic [tbw_pkg::DIV_W-1:0]         num_b,
  output logic [tbw_pkg::DIV_W-1:0]         num_c,
  output logic [tbw_pkg::MAG_W-1:0]         den_mag,
  output tbw_pkg::side_t                    side
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [15:0] e0x_r, e0y_r, e1x_r, e1y_r, e2x_r, e2y_r;
  logic signed [31:0] pd1_r, pd2_r, pb1_r, pb2_r, pc1_r, pc2_r;
  logic signed [32:0] den_r, nb_r, nc_r;
  logic [tbw_pkg::MAG_W-1:0] den_mag_nxt, nb_mag, nc_mag;
  logic [tbw_pkg::DIV_W-1:0] num_b_r, num_c_r;
  logic [tbw_pkg::MAG_W-1:0] den_mag_r;
  tbw_pkg::side_t side_r;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Take magnitudes of the crosses
  always_comb begin
    den_mag_nxt = den_r[32] ? 32'(-den_r) : den_r[31:0];
    nb_mag      = nb_r[32]  ? 32'(-nb_r)  : nb_r[31:0];
    nc_mag      = nc_r[32]  ? 32'(-nc_r)  : nc_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Edge vectors wrap to 16 bits
      e0x_r <= bx - ax;
      e0y_r <= by - ay;
      e1x_r <= cx - ax;
      e1y_r <= cy - ay;
      e2x_r <= px - ax;
      e2y_r <= py - ay;
      // Cross product terms
      pd1_r <= 32'(e0x_r) * 32'(e1y_r);
      pd2_r <= 32'(e0y_r) * 32'(e1x_r);
      pb1_r <= 32'(e2x_r) * 32'(e1y_r);
      pb2_r <= 32'(e2y_r) * 32'(e1x_r);
      pc1_r <= 32'(e0x_r) * 32'(e2y_r);
      pc2_r <= 32'(e0y_r) * 32'(e2x_r);
      // Determinant and numerators
      den_r <= 33'(pd1_r) - 33'(pd2_r);
      nb_r  <= 33'(pb1_r) - 33'(pb2_r);
      nc_r  <= 33'(pc1_r) - 33'(pc2_r);
      // Scale and add half the divisor for rounding
      num_b_r <= (tbw_pkg::DIV_W'(nb_mag) << tbw_pkg::FRAC_BITS)
                 + tbw_pkg::DIV_W'(den_mag_nxt[31:1]);
      num_c_r <= (tbw_pkg::DIV_W'(nc_mag) << tbw_pkg::FRAC_BITS)
                 + tbw_pkg::DIV_W'(den_mag_nxt[31:1]);
      den_mag_r <= den_mag_nxt;
      side_r.neg_b <= nb_r[32] ^ den_r[32];
      side_r.neg_c <= nc_r[32] ^ den_r[32];
      side_r.degen <= (den_r == 33'sd0);
    end
  end

  assign out_v   = v4_r;
  assign num_b   = num_b_r;
  assign num_c   = num_c_r;
  assign den_mag = den_mag_r;
  assign side    = side_r;

endmodule

>>> hdl/tbw_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// Depends on tbw_pkg.
module tbw_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  logic [tbw_pkg::DIV_W-1:0]    num_b,
  input  logic [tbw_pkg::DIV_W-1:0]    num_c,
  input  logic [tbw_pkg::MAG_W-1:0]    den,
  input  tbw_pkg::side_t               side_in,
  output logic                         out_v,
  output logic [tbw_pkg::DIV_W-1:0]    quot_b,
  output logic [tbw_pkg::DIV_W-1:0]    quot_c,
  output tbw_pkg::side_t               side_out
);

  localparam int DW = tbw_pkg::DIV_W;
  localparam int MW = tbw_pkg::MAG_W;

  logic              v_r    [DW];
  logic [MW-1:0]     den_r  [DW];
  logic [MW-1:0]     remb_r [DW];
  logic [MW-1:0]     remc_r [DW];
  logic [DW-1:0]     nb_r   [DW];
  logic [DW-1:0]     nc_r   [DW];
  logic [DW-1:0]     qb_r   [DW];
  logic [DW-1:0]     qc_r   [DW];
  tbw_pkg::side_t    sd_r   [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic           v_i;
    logic [MW-1:0]  den_i, remb_i, remc_i;
    logic [DW-1:0]  nb_i, nc_i, qb_i, qc_i;
    tbw_pkg::side_t sd_i;
    logic [MW:0]    tb, tc;
    logic           geb, gec;

    if (k == 0) begin : g_first
      assign v_i    = in_v;
      assign den_i  = den;
      assign remb_i = '0;
      assign remc_i = '0;
      assign nb_i   = num_b;
      assign nc_i   = num_c;
      assign qb_i   = '0;
      assign qc_i   = '0;
      assign sd_i   = side_in;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign den_i  = den_r[k-1];
      assign remb_i = remb_r[k-1];
      assign remc_i = remc_r[k-1];
      assign nb_i   = nb_r[k-1];
      assign nc_i   = nc_r[k-1];
      assign qb_i   = qb_r[k-1];
      assign qc_i   = qc_r[k-1];
      assign sd_i   = sd_r[k-1];
    end

    // Bring down the next dividend bit and trial subtract
    assign tb  = {remb_i, nb_i[DW-1]};
    assign tc  = {remc_i, nc_i[DW-1]};
    assign geb = (tb >= {1'b0, den_i});
    assign gec = (tc >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_i;
        remb_r[k] <= geb ? MW'(tb - {1'b0, den_i}) : tb[MW-1:0];
        remc_r[k] <= gec ? MW'(tc - {1'b0, den_i}) : tc[MW-1:0];
        nb_r[k]   <= nb_i << 1;
        nc_r[k]   <= nc_i << 1;
        qb_r[k]   <= {qb_i[DW-2:0], geb};
        qc_r[k]   <= {qc_i[DW-2:0], gec};
        sd_r[k]   <= sd_i;
      end
    end
  end

  assign out_v    = v_r[DW-1];
  assign quot_b   = qb_r[DW-1];
  assign quot_c   = qc_r[DW-1];
  assign side_out = sd_r[DW-1];

endmodule

>>> hdl/tbw_back.sv
// Back pipeline: apply signs, form weight of a, saturate into the output register.
// Depends on tbw_pkg.
module tbw_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [tbw_pkg::DIV_W-1:0]   quot_b,
  input  logic [tbw_pkg::DIV_W-1:0]   quot_c,
  input  tbw_pkg::side_t              side,
  output logic                        out_v,
  output logic [31:0]                 wa,
  output logic [31:0]                 wb,
  output logic [31:0]                 wc,
  output logic                        degen
);

  localparam int QW = tbw_pkg::QS_W;
  localparam int AW = tbw_pkg::WA_W;

  logic v1_r, v2_r;
  logic signed [QW-1:0] sb_r, sc_r;
  logic degen1_r, degen_r;
  logic [31:0] wa_r, wb_r, wc_r;
  logic signed [AW-1:0] wa_full, one_fx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  assign one_fx  = AW'(1) <<< tbw_pkg::FRAC_BITS;
  assign wa_full = one_fx - AW'(sb_r) - AW'(sc_r);

  always_ff @(posedge clk) begin
    if (en) begin
      // Apply quotient signs
      sb_r     <= side.neg_b ? -$signed({1'b0, quot_b}) : $signed({1'b0, quot_b});
      sc_r     <= side.neg_c ? -$signed({1'b0, quot_c}) : $signed({1'b0, quot_c});
      degen1_r <= side.degen;
      // Saturate, or zero on a flat triangle
      degen_r  <= degen1_r;
      wa_r     <= degen1_r ? 32'd0 : tbw_pkg::sat32(wa_full);
      wb_r     <= degen1_r ? 32'd0 : tbw_pkg::sat32(AW'(sb_r));
      wc_r     <= degen1_r ? 32'd0 : tbw_pkg::sat32(AW'(sc_r));
    end
  end

  assign out_v = v2_r;
  assign wa    = wa_r;
  assign wb    = wb_r;
  assign wc    = wc_r;
  assign degen = degen_r;

endmodule

>>> hdl/triangle_barycentric_weights_unit.sv
// Pipeline: 4 front stages,
// one divider stage per quotient bit (FRAC_BITS + 33), 2 back stages.
// Throughput: one item per cycle; a stall at the output freezes the whole pipe.
// Reset (rst_n low, synchronous) clears all valid bits; data registers keep values.
// Depends on tbw_pkg, tbw_front, tbw_div, tbw_back and the defines header.
`include "triangle_barycentric_weights_unit_defines.svh"
module triangle_barycentric_weights_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_vert_a_x,
  input  logic signed [15:0] in_vert_a_y,
  input  logic signed [15:0] in_vert_b_x,
  input  logic signed [15:0] in_vert_b_y,
  input  logic signed [15:0] in_vert_c_x,
  input  logic signed [15:0] in_vert_c_y,
  input  logic signed [15:0] in_query_x,
  input  logic signed [15:0] in_query_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_weight_a,
  output logic signed [31:0] out_weight_b,
  output logic signed [31:0] out_weight_c,
  output logic               out_degenerate
);

  logic en;
  logic f_v, d_v;
  logic [tbw_pkg::DIV_W-1:0] f_nb, f_nc, d_qb, d_qc;
  logic [tbw_pkg::MAG_W-1:0] f_den;
  tbw_pkg::side_t f_side, d_side;
  logic [31:0] wa, wb, wc;

  // Advance whenever the output slot is free or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  tbw_front u_front (
    .clk, .rst_n, .en,
    .in_v (in_valid && in_ready),
    .ax (in_vert_a_x), .ay (in_vert_a_y),
    .bx (in_vert_b_x), .by (in_vert_b_y),
    .cx (in_vert_c_x), .cy (in_vert_c_y),
    .px (in_query_x),  .py (in_query_y),
    .out_v (f_v), .num_b (f_nb), .num_c (f_nc), .den_mag (f_den), .side (f_side)
  );

  tbw_div u_div (
    .clk, .rst_n, .en,
    .in_v (f_v), .num_b (f_nb), .num_c (f_nc), .den (f_den), .side_in (f_side),
    .out_v (d_v), .quot_b (d_qb), .quot_c (d_qc), .side_out (d_side)
  );

  tbw_back u_back (
    .clk, .rst_n, .en,
    .in_v (d_v), .quot_b (d_qb), .quot_c (d_qc), .side (d_side),
    .out_v (out_valid), .wa, .wb, .wc, .degen (out_degenerate)
  );

  assign out_weight_a = wa;
  assign out_weight_b = wb;
  assign out_weight_c = wc;

  // Flat triangles give zero weights
  `TBW_ASSERT_IMP(a_degen_zero, out_valid && out_degenerate,
                  out_weight_a == 32'd0 && out_weight_b == 32'd0 && out_weight_c == 32'd0)
  // A stalled result stays put
  `TBW_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                   out_valid && $stable(out_weight_a) && $stable(out_degenerate))
  // Input is taken exactly when the pipe advances
  `TBW_ASSERT_IMP(a_ready_link, out_valid && !out_ready, !in_ready)
  // Front output valid holds while the pipe is frozen
  `TBW_ASSERT_NEXT(a_front_hold, !en, $stable(f_v))

endmodule
